[design/tepq_pkg.sv]
// Package for the timer event queue: sizes, opcodes and payload structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tepq_pkg;
  localparam int QUEUE_DEPTH = 32;
  localparam int MAX_OUT     = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NOUT_W      = $clog2(MAX_OUT + 1);

  localparam logic OP_SCHED = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [15:0] delay;
    logic [7:0]  event_tag;
    logic [31:0] subject_id;
    logic [31:0] target_id;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_tag;
    logic [31:0] out_subject;
    logic [31:0] out_target;
    logic        last_due;
    logic        dropped;
  } out_t;

  typedef struct packed {
    logic [31:0] wake;
    logic [15:0] order;
    logic [7:0]  tag;
    logic [31:0] subject;
    logic [31:0] target;
  } entry_t;
endpackage
`default_nettype wire

[design/timer_event_priority_queue.sv]
// Timer event queue top level: entry memory, due scan and compaction.
// Depends on tepq_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Usage: drive in_data and pulse start while busy is low; the transaction is
// taken at that edge. A schedule is written to the entry memory in the same
// cycle and gives no result; busy stays low, so schedules go one per cycle.
// A schedule into a full queue gives one result with dropped and last_due set,
// in the following cycle. A tick raises busy and advances the time by one.
// The block then scans the memory, one entry read per cycle, for the earliest
// due entry, and closes the gap it leaves by moving later entries down one
// slot, one per cycle. Both steps are bounded by the single read port of the
// entry memory. Each result is held back until the next scan, or the MAX_OUT
// limit, shows whether it is the last, and then shown for one cycle with
// out_valid; the receiver cannot stall. At most MAX_OUT results per tick.
// Reset empties the queue and zeroes time and order numbers; memory contents
// need no clearing.
module timer_event_priority_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire tepq_pkg::in_t  in_data,
  output logic                out_valid,
  output tepq_pkg::out_t      out_data
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MOVE} state_t;

  tepq_pkg::entry_t mem [tepq_pkg::QUEUE_DEPTH];
  tepq_pkg::entry_t mem_q;

  state_t                      state_r;
  logic [tepq_pkg::CNT_W-1:0]  count_r;
  logic [31:0]                 time_r;
  logic [15:0]                 order_r;
  logic [tepq_pkg::CNT_W-1:0]  rd_idx_r;
  logic                        rv_r;
  logic [tepq_pkg::CNT_W-1:0]  rv_idx_r;
  logic                        found_r;
  logic [31:0]                 best_age_r;
  logic [15:0]                 best_oage_r;
  logic [tepq_pkg::IDX_W-1:0]  best_idx_r;
  tepq_pkg::entry_t            best_r;
  logic                        pend_r;
  tepq_pkg::entry_t            pend_data_r;
  logic [tepq_pkg::NOUT_W-1:0] nout_r;
  logic                        out_valid_r;
  tepq_pkg::out_t              out_data_r;

  logic                        accept;
  logic                        wr_en;
  logic [tepq_pkg::IDX_W-1:0]  wr_addr;
  tepq_pkg::entry_t            wr_data;
  logic [tepq_pkg::IDX_W-1:0]  rd_addr;
  logic                        issue;
  logic [31:0]                 diff, age;
  logic [15:0]                 oage;
  logic                        due, better;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign issue  = (rd_idx_r < count_r);
  assign rd_addr = rd_idx_r[tepq_pkg::IDX_W-1:0];

  assign diff   = mem_q.wake - time_r;
  assign due    = (diff == 32'd0) || diff[31];
  assign age    = time_r - mem_q.wake;
  assign oage   = order_r - mem_q.order;
  assign better = !found_r || (age > best_age_r) ||
                  ((age == best_age_r) && (oage > best_oage_r));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[tepq_pkg::IDX_W-1:0];
    wr_data = mem_q;
    if (state_r == S_IDLE) begin
      wr_en   = accept && (in_data.opcode == tepq_pkg::OP_SCHED) &&
                (count_r != tepq_pkg::CNT_W'(tepq_pkg::QUEUE_DEPTH));
      wr_data.wake    = time_r + 32'(in_data.delay);
      wr_data.order   = order_r;
      wr_data.tag     = in_data.event_tag;
      wr_data.subject = in_data.subject_id;
      wr_data.target  = in_data.target_id;
    end else if (state_r == S_MOVE) begin
      wr_en   = rv_r;
      wr_addr = tepq_pkg::IDX_W'(rv_idx_r - tepq_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      time_r      <= '0;
      order_r     <= '0;
      rd_idx_r    <= '0;
      rv_r        <= 1'b0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      nout_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_data.opcode == tepq_pkg::OP_SCHED) begin
              if (count_r == tepq_pkg::CNT_W'(tepq_pkg::QUEUE_DEPTH)) begin
                out_valid_r <= 1'b1;
                out_data_r  <= '{out_tag: 8'd0, out_subject: 32'd0,
                                 out_target: 32'd0, last_due: 1'b1, dropped: 1'b1};
              end else begin
                count_r <= count_r + tepq_pkg::CNT_W'(1);
                order_r <= order_r + 16'd1;
              end
            end else begin
              time_r   <= time_r + 32'd1;
              state_r  <= S_SCAN;
              rd_idx_r <= '0;
              rv_r     <= 1'b0;
              found_r  <= 1'b0;
              pend_r   <= 1'b0;
              nout_r   <= '0;
            end
          end
        end
        S_SCAN: begin
          rv_r     <= issue;
          rv_idx_r <= rd_idx_r;
          if (issue) begin
            rd_idx_r <= rd_idx_r + tepq_pkg::CNT_W'(1);
          end
          if (rv_r && due && better) begin
            found_r     <= 1'b1;
            best_age_r  <= age;
            best_oage_r <= oage;
            best_idx_r  <= rv_idx_r[tepq_pkg::IDX_W-1:0];
            best_r      <= mem_q;
          end
          if (!issue && !rv_r) begin
            if (found_r) begin
              if (pend_r) begin
                out_valid_r <= 1'b1;
                out_data_r  <= '{out_tag: pend_data_r.tag, out_subject: pend_data_r.subject,
                                 out_target: pend_data_r.target, last_due: 1'b0,
                                 dropped: 1'b0};
              end
              pend_r      <= 1'b1;
              pend_data_r <= best_r;
              nout_r      <= nout_r + tepq_pkg::NOUT_W'(1);
              rd_idx_r    <= tepq_pkg::CNT_W'(best_idx_r) + tepq_pkg::CNT_W'(1);
              state_r     <= S_MOVE;
            end else begin
              if (pend_r) begin
                out_valid_r <= 1'b1;
                out_data_r  <= '{out_tag: pend_data_r.tag, out_subject: pend_data_r.subject,
                                 out_target: pend_data_r.target, last_due: 1'b1,
                                 dropped: 1'b0};
              end
              pend_r  <= 1'b0;
              state_r <= S_IDLE;
            end
          end
        end
        S_MOVE: begin
          rv_r     <= issue;
          rv_idx_r <= rd_idx_r;
          if (issue) begin
            rd_idx_r <= rd_idx_r + tepq_pkg::CNT_W'(1);
          end
          if (!issue && !rv_r) begin
            count_r  <= count_r - tepq_pkg::CNT_W'(1);
            found_r  <= 1'b0;
            rd_idx_r <= '0;
            if (nout_r == tepq_pkg::NOUT_W'(tepq_pkg::MAX_OUT)) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '{out_tag: pend_data_r.tag, out_subject: pend_data_r.subject,
                               out_target: pend_data_r.target, last_due: 1'b1,
                               dropped: 1'b0};
              pend_r  <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tepq_pkg::CNT_W'(tepq_pkg::QUEUE_DEPTH))
    else $error("entry count above depth");
  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.dropped) |-> out_data.last_due)
    else $error("dropped result not marked last");
  a_sched_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.opcode == tepq_pkg::OP_SCHED &&
     count_r != tepq_pkg::CNT_W'(tepq_pkg::QUEUE_DEPTH))
    |=> (count_r == $past(count_r) + tepq_pkg::CNT_W'(1)))
    else $error("schedule did not add an entry");
  a_move_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> pend_r)
    else $error("compaction without a pending result");
endmodule
`default_nettype wire
